// ----- rtl/rhp_pkg.sv -----
// Shared types, status codes and constants of the RTP header parser.
`default_nettype none

package rhp_pkg;

  // Widest packet length the parser can report (a count of up to 2^16 bytes).
  localparam int unsigned LEN_W = 17;
  // Width of header offsets: fixed header, CSRC list and a 16-bit word count times four.
  localparam int unsigned OFF_W = 19;
  // Entries in the queue between the byte front end and the check pipeline.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned FIXED_HDR_BYTES = 12;
  localparam logic [1:0]  RTP_VERSION     = 2'd2;

  // Status codes, in the order the checks are made, but for ST_TOO_LONG, checked after ST_BAD_VERSION.
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SHORT       = 4'd1;
  localparam logic [3:0] ST_BAD_VERSION = 4'd2;
  localparam logic [3:0] ST_CSRC_CUT    = 4'd3;
  localparam logic [3:0] ST_EXT_HDR_CUT = 4'd4;
  localparam logic [3:0] ST_EXT_CUT     = 4'd5;
  localparam logic [3:0] ST_PAD_EMPTY   = 4'd6;
  localparam logic [3:0] ST_PAD_BAD     = 4'd7;
  localparam logic [3:0] ST_TOO_LONG    = 4'd8;

  // One packet byte as it arrives.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rhp_byte_t;

  // One parse result per packet.
  typedef struct packed {
    logic [3:0]  status;
    logic        padding_flag;
    logic        extension_flag;
    logic [3:0]  csrc_count;
    logic        marker_flag;
    logic [6:0]  payload_type;
    logic [15:0] sequence_number;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [15:0] header_size;
    logic [15:0] payload_size;
  } rhp_result_t;

  // Everything the front end knows about a packet once its last byte is in.
  typedef struct packed {
    logic [7:0]       hdr0;
    logic [7:0]       hdr1;
    logic [15:0]      seq;
    logic [31:0]      ts;
    logic [31:0]      ssrc;
    logic [15:0]      ext_words;
    logic [LEN_W-1:0] len;
    logic [7:0]       last_data;
    logic             overlength;
  } rhp_pkt_info_t;

endpackage

`default_nettype wire

// ----- rtl/rhp_stream_if.sv -----
// Valid/ready stream interface that carries one payload of a chosen type.
`default_nettype none

interface rhp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/rhp_front.sv -----
// Byte front end: counts positions, captures header fields, emits a packet summary.
`default_nettype none

module rhp_front #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  rhp_pkg::rhp_byte_t    in_byte,
  output logic                  push,
  output rhp_pkg::rhp_pkt_info_t info
);
  import rhp_pkg::*;

  localparam int unsigned LW = LENGTH_WIDTH;

  logic [LW-1:0] byte_position, byte_position_next;
  logic [7:0]    first_header_byte, first_header_byte_next;
  logic [7:0]    second_header_byte, second_header_byte_next;
  logic [15:0]   sequence_reg, sequence_reg_next;
  logic [31:0]   timestamp_reg, timestamp_reg_next;
  logic [31:0]   source_reg, source_reg_next;
  logic [15:0]   extension_words, extension_words_next;
  logic          overlength_flag, overlength_flag_next;

  logic          at_max;
  logic          capture;
  logic [6:0]    ext_at;
  logic [7:0]    b;

  assign b       = in_byte.data_byte;
  assign at_max  = &byte_position;
  assign capture = accept && !at_max;
  // The extension word count sits two bytes past the end of the CSRC list.
  assign ext_at  = 7'(FIXED_HDR_BYTES + 2) + 7'({first_header_byte[3:0], 2'b00});

  // Capture the byte at its position and advance the saturating count.
  always_comb begin
    byte_position_next      = byte_position;
    first_header_byte_next  = first_header_byte;
    second_header_byte_next = second_header_byte;
    sequence_reg_next       = sequence_reg;
    timestamp_reg_next      = timestamp_reg;
    source_reg_next         = source_reg;
    extension_words_next    = extension_words;
    overlength_flag_next    = overlength_flag | (accept & at_max);
    if (capture) begin
      byte_position_next = byte_position + LW'(1);
      if (byte_position == LW'(0)) begin
        first_header_byte_next = b;
      end else if (byte_position == LW'(1)) begin
        second_header_byte_next = b;
      end else if (byte_position < LW'(4)) begin
        sequence_reg_next = {sequence_reg[7:0], b};
      end else if (byte_position < LW'(8)) begin
        timestamp_reg_next = {timestamp_reg[23:0], b};
      end else if (byte_position < LW'(FIXED_HDR_BYTES)) begin
        source_reg_next = {source_reg[23:0], b};
      end
      if (byte_position == LW'(ext_at) || byte_position == LW'(ext_at) + LW'(1)) begin
        extension_words_next = {extension_words[7:0], b};
      end
    end
  end

  // The summary includes whatever the last byte itself captured.
  assign push = accept && in_byte.last_byte;

  always_comb begin
    info.hdr0       = first_header_byte_next;
    info.hdr1       = second_header_byte_next;
    info.seq        = sequence_reg_next;
    info.ts         = timestamp_reg_next;
    info.ssrc       = source_reg_next;
    info.ext_words  = extension_words_next;
    info.len        = LEN_W'(byte_position) + LEN_W'(1);
    info.last_data  = b;
    info.overlength = overlength_flag_next;
  end

  // Packet state clears after each last byte.
  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_position      <= '0;
      first_header_byte  <= '0;
      second_header_byte <= '0;
      sequence_reg       <= '0;
      timestamp_reg      <= '0;
      source_reg         <= '0;
      extension_words    <= '0;
      overlength_flag    <= 1'b0;
    end else if (accept) begin
      byte_position      <= byte_position_next;
      first_header_byte  <= first_header_byte_next;
      second_header_byte <= second_header_byte_next;
      sequence_reg       <= sequence_reg_next;
      timestamp_reg      <= timestamp_reg_next;
      source_reg         <= source_reg_next;
      extension_words    <= extension_words_next;
      overlength_flag    <= overlength_flag_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rhp_queue.sv -----
// Short queue of packet summaries between the front end and the check pipeline.
`default_nettype none

module rhp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  rhp_pkg::rhp_pkt_info_t push_data,
  output logic                   full,
  input  logic                   pop,
  output logic                   not_empty,
  output rhp_pkg::rhp_pkt_info_t pop_data
);
  import rhp_pkg::*;

  // Pointers wrap naturally because the depth is a power of two.
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  rhp_pkt_info_t    entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entries[rd_ptr];

  // Storage for queued summaries.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rhp_back.sv -----
// Check pipeline: runs the header checks on a packet summary and registers the result.
`default_nettype none

module rhp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  rhp_pkg::rhp_pkt_info_t q_data,
  output logic                   q_pop,
  rhp_stream_if.source           result
);
  import rhp_pkg::*;

  typedef struct packed {
    logic [7:0]       hdr0;
    logic [7:0]       hdr1;
    logic [15:0]      seq;
    logic [31:0]      ts;
    logic [31:0]      ssrc;
    logic [LEN_W-1:0] len;
    logic [7:0]       last_data;
    logic [3:0]       status;
    logic [6:0]       off;
    logic [7:0]       off4;
    logic [OFF_W-1:0] offx;
  } stage1_t;

  typedef struct packed {
    logic [7:0]       hdr0;
    logic [7:0]       hdr1;
    logic [15:0]      seq;
    logic [31:0]      ts;
    logic [31:0]      ssrc;
    logic [7:0]       last_data;
    logic [3:0]       status;
    logic [OFF_W-1:0] off_sel;
    logic [LEN_W-1:0] payload;
  } stage2_t;

  stage1_t          s1, s1_next;
  stage2_t          s2, s2_next;
  rhp_result_t      res_next;
  logic             s1_valid;
  logic             s2_valid;
  logic             s1_ready;
  logic             s2_ready;
  logic             s3_ready;
  logic             ext2;
  logic             pad3;
  logic [OFF_W-1:0] len2;
  logic [OFF_W-1:0] diff2;
  logic [LEN_W-1:0] pay3;
  logic [3:0]       st3;

  // Each stage moves when it is empty or its successor takes its contents.
  assign s3_ready = !result.valid || result.ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign q_pop    = q_valid && s1_ready;

  // Stage 1: early checks and the candidate header offsets.
  always_comb begin
    s1_next.hdr0      = q_data.hdr0;
    s1_next.hdr1      = q_data.hdr1;
    s1_next.seq       = q_data.seq;
    s1_next.ts        = q_data.ts;
    s1_next.ssrc      = q_data.ssrc;
    s1_next.len       = q_data.len;
    s1_next.last_data = q_data.last_data;
    if (q_data.len < LEN_W'(FIXED_HDR_BYTES)) begin
      s1_next.status = ST_SHORT;
    end else if (q_data.hdr0[7:6] != RTP_VERSION) begin
      s1_next.status = ST_BAD_VERSION;
    end else if (q_data.overlength) begin
      s1_next.status = ST_TOO_LONG;
    end else begin
      s1_next.status = ST_OK;
    end
    s1_next.off  = 7'(FIXED_HDR_BYTES) + 7'({q_data.hdr0[3:0], 2'b00});
    s1_next.off4 = 8'(s1_next.off) + 8'd4;
    s1_next.offx = OFF_W'(s1_next.off4) + OFF_W'({q_data.ext_words, 2'b00});
  end

  // Stage 2: length checks against the header layout and the raw payload size.
  assign ext2  = s1.hdr0[4];
  assign len2  = OFF_W'(s1.len);

  always_comb begin
    s2_next.hdr0      = s1.hdr0;
    s2_next.hdr1      = s1.hdr1;
    s2_next.seq       = s1.seq;
    s2_next.ts        = s1.ts;
    s2_next.ssrc      = s1.ssrc;
    s2_next.last_data = s1.last_data;
    if (s1.status != ST_OK) begin
      s2_next.status = s1.status;
    end else if (OFF_W'(s1.off) > len2) begin
      s2_next.status = ST_CSRC_CUT;
    end else if (ext2 && OFF_W'(s1.off4) > len2) begin
      s2_next.status = ST_EXT_HDR_CUT;
    end else if (ext2 && s1.offx > len2) begin
      s2_next.status = ST_EXT_CUT;
    end else begin
      s2_next.status = ST_OK;
    end
    s2_next.off_sel = ext2 ? s1.offx : OFF_W'(s1.off);
    diff2           = len2 - s2_next.off_sel;
    s2_next.payload = diff2[LEN_W-1:0];
  end

  // Stage 3: padding checks and the final result fields.
  assign pad3 = s2.hdr0[5];

  always_comb begin
    pay3 = s2.payload;
    st3  = s2.status;
    if (s2.status == ST_OK && pad3) begin
      if (s2.payload == '0) begin
        st3 = ST_PAD_EMPTY;
      end else if (s2.last_data == 8'd0 || LEN_W'(s2.last_data) > s2.payload) begin
        st3 = ST_PAD_BAD;
      end else begin
        pay3 = s2.payload - LEN_W'(s2.last_data);
      end
    end
    res_next.status          = st3;
    res_next.padding_flag    = s2.hdr0[5];
    res_next.extension_flag  = s2.hdr0[4];
    res_next.csrc_count      = s2.hdr0[3:0];
    res_next.marker_flag     = s2.hdr1[7];
    res_next.payload_type    = s2.hdr1[6:0];
    res_next.sequence_number = s2.seq;
    res_next.time_stamp      = s2.ts;
    res_next.source_id       = s2.ssrc;
    res_next.header_size     = (st3 == ST_OK) ? s2.off_sel[15:0] : 16'd0;
    res_next.payload_size    = (st3 == ST_OK) ? pay3[15:0] : 16'd0;
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1 <= s1_next;
    end
    if (s2_ready) begin
      s2 <= s2_next;
    end
    if (s3_ready) begin
      result.data <= res_next;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= q_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        result.valid <= s2_valid;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rtp_header_parser.sv -----
// A packet's summary is queued as its last byte is accepted and then registered in
// check stages 1, 2 and 3. Throughput: one byte per cycle while the queue has room;
// a result can leave every cycle the receiver is ready, via the three-stage pipeline.
// Input stalls only when the two-entry summary queue is full.
// Reset (synchronous, active high) clears the byte count, captured fields, queue and
// all pipeline valid flags; the block accepts bytes in the first cycle after reset.
`default_nettype none

module rtp_header_parser #(
  // Packet length counter width, 8 to 16; longer packets report too long.
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  rhp_stream_if.sink   packet,
  rhp_stream_if.source result
);
  import rhp_pkg::*;

  logic          accept;
  logic          push;
  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;
  rhp_pkt_info_t push_info;
  rhp_pkt_info_t pop_info;

  // A byte transaction completes whenever the queue has room for a summary.
  assign packet.ready = !q_full;
  assign accept       = packet.valid && packet.ready;

  rhp_front #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (packet.data),
    .push    (push),
    .info    (push_info)
  );

  rhp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_info),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_info)
  );

  rhp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_not_empty),
    .q_data  (pop_info),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

`default_nettype wire

// ----- rtl/rhp_checker.sv -----
// Port-level assertions for the RTP header parser and the bind that attaches them.
`default_nettype none

module rhp_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_ready,
  input rhp_pkg::rhp_result_t res_data
);
  import rhp_pkg::*;

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A stalled result transaction holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // A failed packet reports zero header and payload sizes.
  a_fail_sizes: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != ST_OK |->
      res_data.header_size == 16'd0 && res_data.payload_size == 16'd0)
    else $error("failed packet carries sizes");

  // A good header is at least the fixed header and a whole number of words.
  a_ok_header: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status == ST_OK |->
      res_data.header_size >= 16'(FIXED_HDR_BYTES) && res_data.header_size[1:0] == 2'b00)
    else $error("bad header size on good packet");

  // Status stays within the defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.status <= ST_TOO_LONG)
    else $error("undefined status code");

endmodule

bind rtp_header_parser rhp_checker u_rhp_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);

`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the RTP header parser: directed and random packets checked against a predictor.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rhp_pkg::*;

  localparam int unsigned LENGTH_WIDTH = 16;
  localparam int unsigned MAX_COUNT = (1 << LENGTH_WIDTH) - 1;
  // Result latency after the last byte is accepted.
  localparam int unsigned LATENCY = 3;
  localparam int unsigned MAX_BURST = 16;
  localparam int unsigned MAX_GAP = 5;

  typedef logic [7:0] byte_list_t[$];

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold;  // wait for all results to drain before sending this byte
  } pkt_byte_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhp_stream_if #(.T(rhp_byte_t))   packet_if ();
  rhp_stream_if #(.T(rhp_result_t)) result_if ();

  rtp_header_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .packet(packet_if),
    .result(result_if)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stimulus, expectations and bookkeeping.
  pkt_byte_t   pending_bytes[$];
  rhp_result_t expected_results[$];
  int unsigned bytes_total = 0;
  int unsigned pkts_total = 0;
  int unsigned mismatches = 0;
  longint      cycles = 0;
  longint      cycle_limit = 64'd50_000_000;
  int unsigned quiet_cycles = 0;
  bit          byte_fire = 1'b0;

  // Predictor state, starting cleared and cleared again after every last byte.
  int unsigned rx_count = 0;
  logic [7:0]  hdr_b0 = '0;
  logic [7:0]  hdr_b1 = '0;
  logic [15:0] seq_shift = '0;
  logic [31:0] ts_shift = '0;
  logic [31:0] ssrc_shift = '0;
  logic [15:0] ext_len_shift = '0;
  bit          count_saturated = 1'b0;

  // Driver and receiver state.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned mode_left = 0;

  // Update the parser state with one accepted byte; on the last byte compute the result.
  task automatic parse_packet_byte(input logic [7:0] b, input logic last);
    int unsigned idx, len, off, pay, ext_at, cc;
    logic [3:0]  st;
    rhp_result_t want;
    idx = rx_count;
    if (idx >= MAX_COUNT) begin
      count_saturated = 1'b1;
    end else begin
      ext_at = FIXED_HDR_BYTES + 32'(hdr_b0[3:0]) * 4 + 2;
      if (idx == 0) begin
        hdr_b0 = b;
      end else if (idx == 1) begin
        hdr_b1 = b;
      end else if (idx < 4) begin
        seq_shift = {seq_shift[7:0], b};
      end else if (idx < 8) begin
        ts_shift = {ts_shift[23:0], b};
      end else if (idx < 12) begin
        ssrc_shift = {ssrc_shift[23:0], b};
      end
      // The extension word count is captured whether or not the extension bit is set.
      if (idx == ext_at || idx == ext_at + 1) begin
        ext_len_shift = {ext_len_shift[7:0], b};
      end
      rx_count = idx + 1;
    end
    if (last) begin
      len = idx + 1;
      cc = 32'(hdr_b0[3:0]);
      off = 0;
      pay = 0;
      st = ST_OK;
      // Checks in priority order; the first failing one sets the status.
      if (len < FIXED_HDR_BYTES) begin
        st = ST_SHORT;
      end else if (hdr_b0[7:6] != RTP_VERSION) begin
        st = ST_BAD_VERSION;
      end else if (count_saturated) begin
        st = ST_TOO_LONG;
      end else begin
        off = FIXED_HDR_BYTES + cc * 4;
        if (off > len) begin
          st = ST_CSRC_CUT;
        end else if (hdr_b0[4] && off + 4 > len) begin
          st = ST_EXT_HDR_CUT;
        end else if (hdr_b0[4] && off + 4 + 32'(ext_len_shift) * 4 > len) begin
          st = ST_EXT_CUT;
        end else begin
          if (hdr_b0[4]) off = off + 4 + 32'(ext_len_shift) * 4;
          pay = len - off;
          if (hdr_b0[5]) begin
            if (pay == 0) begin
              st = ST_PAD_EMPTY;
            end else if (b == 8'd0 || 32'(b) > pay) begin
              st = ST_PAD_BAD;
            end else begin
              pay = pay - 32'(b);
            end
          end
        end
      end
      if (st != ST_OK) begin
        off = 0;
        pay = 0;
      end
      want.status = st;
      want.padding_flag = hdr_b0[5];
      want.extension_flag = hdr_b0[4];
      want.csrc_count = hdr_b0[3:0];
      want.marker_flag = hdr_b1[7];
      want.payload_type = hdr_b1[6:0];
      want.sequence_number = seq_shift;
      want.time_stamp = ts_shift;
      want.source_id = ssrc_shift;
      want.header_size = off[15:0];
      want.payload_size = pay[15:0];
      expected_results.push_back(want);
      rx_count = 0;
      hdr_b0 = '0;
      hdr_b1 = '0;
      seq_shift = '0;
      ts_shift = '0;
      ssrc_shift = '0;
      ext_len_shift = '0;
      count_saturated = 1'b0;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch in %s at cycle %0d: expected %0h, actual %0h", name, cycles, want,
                 got);
      end
    end
  endtask

  // Compare one result transaction with the oldest expected result.
  task automatic check_parse_result(input rhp_result_t got);
    rhp_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Unexpected result at cycle %0d: status %0d", cycles, got.status);
      end
    end else begin
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("padding_flag", want.padding_flag, got.padding_flag);
      compare_field("extension_flag", want.extension_flag, got.extension_flag);
      compare_field("csrc_count", want.csrc_count, got.csrc_count);
      compare_field("marker_flag", want.marker_flag, got.marker_flag);
      compare_field("payload_type", want.payload_type, got.payload_type);
      compare_field("sequence_number", want.sequence_number, got.sequence_number);
      compare_field("time_stamp", want.time_stamp, got.time_stamp);
      compare_field("source_id", want.source_id, got.source_id);
      compare_field("header_size", want.header_size, got.header_size);
      compare_field("payload_size", want.payload_size, got.payload_size);
    end
  endtask

  // Packet with two given header bytes and every later byte set to one fill value.
  task automatic fill_packet(output byte_list_t pk, input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] fill, input int unsigned n);
    pk.delete();
    pk.push_back(b0);
    if (n > 1) pk.push_back(b1);
    for (int unsigned i = 2; i < n; i++) pk.push_back(fill);
  endtask

  task automatic queue_packet(input byte_list_t pk, input bit hold);
    pkt_byte_t item;
    for (int unsigned i = 0; i < pk.size(); i++) begin
      item.data = pk[i];
      item.last = (i == pk.size() - 1);
      item.hold = hold && (i == 0);
      pending_bytes.push_back(item);
    end
    bytes_total += pk.size();
    pkts_total++;
  endtask

  // Mostly well-formed packets with random content; some are cut, damaged or pure noise.
  task automatic queue_random_packet();
    byte_list_t  pk;
    int unsigned cc, words, body, padn, n;
    logic        pad, ext;
    pad = 1'($urandom_range(0, 1));
    ext = 1'($urandom_range(0, 1));
    cc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 1);
    words = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 2);
    body = $urandom_range(0, 12);
    padn = pad ? $urandom_range(1, 4) : 0;
    pk.push_back({2'b10, pad, ext, cc[3:0]});
    repeat (11 + cc * 4) pk.push_back(8'($urandom));
    if (ext) begin
      pk.push_back(8'($urandom));
      pk.push_back(8'($urandom));
      pk.push_back(8'(words >> 8));
      pk.push_back(8'(words));
      repeat (words * 4) pk.push_back(8'($urandom));
    end
    repeat (body) pk.push_back(8'($urandom));
    if (pad) begin
      repeat (padn - 1) pk.push_back(8'($urandom));
      pk.push_back(8'(padn));
    end
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(1, pk.size());
        while (pk.size() > n) void'(pk.pop_back());
      end
      1: pk[0] = {2'($urandom_range(0, 3)), pk[0][5:0]};
      2: pk[pk.size() - 1] = 8'($urandom);
      3: begin
        pk.delete();
        repeat ($urandom_range(1, 24)) pk.push_back(8'($urandom));
      end
      default: ;
    endcase
    queue_packet(pk, $urandom_range(0, 11) == 0);
  endtask

  // Monitor: sample both channels at the rising edge and run the predictor and checker.
  always @(posedge clk) begin
    cycles++;
    if (cycles > cycle_limit) begin
      $display("Verification failed");
      $finish;
    end else begin
      byte_fire = !rst && packet_if.valid && packet_if.ready;
      if (byte_fire) begin
        parse_packet_byte(packet_if.data.data_byte, packet_if.data.last_byte);
      end
      if (!rst && result_if.valid && result_if.ready) begin
        check_parse_result(result_if.data);
      end
      quiet_cycles = (expected_results.size() == 0) ? quiet_cycles + 1 : 0;
    end
  end

  // Driver: present bytes in bursts with random gaps; valid holds until the transaction.
  always @(negedge clk) begin
    bit next_valid;
    if (rst) begin
      packet_if.valid <= 1'b0;
    end else begin
      if (byte_fire) void'(pending_bytes.pop_front());
      next_valid = packet_if.valid && !byte_fire;
      if (!next_valid && pending_bytes.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_bytes[0].hold &&
                     !(expected_results.size() == 0 && quiet_cycles > LATENCY + 2)) begin
          // Hold off until every outstanding result has come back.
        end else begin
          next_valid = 1'b1;
          packet_if.data <= {pending_bytes[0].data, pending_bytes[0].last};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, MAX_BURST);
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, MAX_GAP);
          end else begin
            burst_left--;
          end
        end
      end
      packet_if.valid <= next_valid;
    end
  end

  // Receiver: ready follows a stall pattern that changes mode now and then.
  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_ALWAYS:   result_if.ready <= 1'b1;
        RX_COIN:     result_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   result_if.ready <= ($urandom_range(0, 3) == 0);
        default:     result_if.ready <= (mode_left % 4) != 0;
      endcase
    end
  end

  // Build the stimulus, release reset, then wait for everything to drain.
  initial begin
    byte_list_t  pk;
    packet_if.valid = 1'b0;
    packet_if.data = '0;
    result_if.ready = 1'b0;

    // Short packets: one byte, and one byte less than a fixed header.
    fill_packet(pk, 8'h80, 8'h00, 8'h00, 1);
    queue_packet(pk, 1'b0);
    fill_packet(pk, 8'h80, 8'h12, 8'h5A, 11);
    queue_packet(pk, 1'b0);
    // Bare fixed header with all-zero fields, sent after the pipeline drains.
    fill_packet(pk, 8'h80, 8'h00, 8'h00, 12);
    queue_packet(pk, 1'b1);
    // All-ones marker, payload type, sequence, timestamp and source fields, small payload.
    fill_packet(pk, 8'h80, 8'hFF, 8'hFF, 15);
    queue_packet(pk, 1'b0);
    // Bad version, both low and high.
    fill_packet(pk, 8'h00, 8'h60, 8'h33, 12);
    queue_packet(pk, 1'b0);
    fill_packet(pk, 8'hFF, 8'hFF, 8'hFF, 20);
    queue_packet(pk, 1'b0);
    // CSRC list longer than the packet.
    fill_packet(pk, 8'h8F, 8'h01, 8'h44, 20);
    queue_packet(pk, 1'b0);
    // Extension header cut short.
    fill_packet(pk, 8'h90, 8'h02, 8'h21, 14);
    queue_packet(pk, 1'b0);
    // Extension body longer than the packet (largest word count).
    fill_packet(pk, 8'h90, 8'h02, 8'hFF, 16);
    queue_packet(pk, 1'b0);
    // Padding with no payload.
    fill_packet(pk, 8'hA0, 8'h03, 8'h11, 12);
    queue_packet(pk, 1'b0);
    // Padding count of zero, and padding count beyond the payload.
    fill_packet(pk, 8'hA0, 8'h04, 8'h11, 13);
    pk[12] = 8'h00;
    queue_packet(pk, 1'b0);
    fill_packet(pk, 8'hA0, 8'h05, 8'h11, 14);
    pk[13] = 8'h03;
    queue_packet(pk, 1'b0);
    // Padding that takes the whole payload.
    fill_packet(pk, 8'hA0, 8'h05, 8'h11, 14);
    pk[13] = 8'h02;
    queue_packet(pk, 1'b0);
    // Every flag, fifteen CSRCs, a one-word extension and one pad byte.
    fill_packet(pk, 8'hBF, 8'hFF, 8'hFF, 85);
    pk[74] = 8'h00;
    pk[75] = 8'h01;
    pk[84] = 8'h01;
    queue_packet(pk, 1'b0);
    // Extension count bytes present but ignored because the extension bit is clear.
    fill_packet(pk, 8'h80, 8'h06, 8'hC3, 20);
    queue_packet(pk, 1'b0);

    // Random packets fill up the rest of the byte budget.
    while (bytes_total < 1150) begin
      queue_random_packet();
    end

    cycle_limit = 3 * (longint'(bytes_total) * (MAX_GAP + 1) + longint'(pkts_total) * 64)
                  + 10_000;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- rtp_header_parser.f -----
rtl/rhp_pkg.sv
rtl/rhp_stream_if.sv
rtl/rhp_front.sv
rtl/rhp_queue.sv
rtl/rhp_back.sv
rtl/rtp_header_parser.sv
rtl/rhp_checker.sv
dv/tb.sv
